### rtl/core/tensor_index_coordinate_converter_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the tensor index coordinate converter.
// Every macro samples on clk and is disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef TENSOR_INDEX_COORDINATE_CONVERTER_DEFINES_SVH
`define TENSOR_INDEX_COORDINATE_CONVERTER_DEFINES_SVH

// Plain property checked at every clock edge.
`define TICC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define TICC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/core/ticc_pkg.sv
// ---------------------------------------------------------------------------
// ticc_pkg
// Shared types and constants of the tensor index coordinate converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ticc_pkg;

	localparam int FLAT_W      = 32;
	localparam int COUNT_W     = 3;
	localparam int CFG_IDX_W   = 4;
	localparam int DIV_STEPS   = 4;

	localparam logic [CFG_IDX_W-1:0] REG_SHAPE_RANK = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_BASE   = 4'd1;

	localparam logic CMD_FOLD  = 1'b0;
	localparam logic CMD_SPLIT = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [3:0] given;
	} ctl_t;

endpackage

### rtl/core/ticc_stage.sv
// ---------------------------------------------------------------------------
// ticc_stage
// One pipeline stage: a few restoring division steps of the split path and,
// in the first two stages of a dimension, one multiply of the fold path.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ticc_stage #(
	parameter int MAX_RANK  = 6,
	parameter int DIM_WIDTH = 16,
	parameter int SECT      = 0,
	parameter int SUB       = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [3:0]                  rank,
	input  logic [DIM_WIDTH-1:0]        dim [MAX_RANK],
	input  logic                        vld_i,
	input  ticc_pkg::ctl_t              ctl_i,
	input  logic [ticc_pkg::FLAT_W-1:0] acc_i,
	input  logic [ticc_pkg::FLAT_W-1:0] pw_i,
	input  logic [ticc_pkg::FLAT_W-1:0] prod_i,
	input  logic [ticc_pkg::FLAT_W-1:0] num_i,
	input  logic [DIM_WIDTH-1:0]        rem_i,
	input  logic [DIM_WIDTH-1:0]        crd_i [MAX_RANK],
	input  logic [DIM_WIDTH-1:0]        cin_i [MAX_RANK],
	output logic                        vld_o,
	output ticc_pkg::ctl_t              ctl_o,
	output logic [ticc_pkg::FLAT_W-1:0] acc_o,
	output logic [ticc_pkg::FLAT_W-1:0] pw_o,
	output logic [ticc_pkg::FLAT_W-1:0] prod_o,
	output logic [ticc_pkg::FLAT_W-1:0] num_o,
	output logic [DIM_WIDTH-1:0]        rem_o,
	output logic [DIM_WIDTH-1:0]        crd_o [MAX_RANK],
	output logic [DIM_WIDTH-1:0]        cin_o [MAX_RANK]
);

	localparam int FW    = ticc_pkg::FLAT_W;
	localparam int STEPS = ticc_pkg::DIV_STEPS;
	localparam int SUBS  = FW / STEPS;

	logic [FW-1:0]        acc_n, pw_n, prod_n, num_n;
	logic [DIM_WIDTH-1:0] rem_n;
	logic [DIM_WIDTH-1:0] crd_n [MAX_RANK];
	logic                 incl;

	always_comb begin
		logic [DIM_WIDTH:0]   t;
		logic [DIM_WIDTH-1:0] r;
		logic [FW-1:0]        q;
		if (SECT == 0) begin
			incl = ctl_i.given != 4'd0;
		end else begin
			incl = (4'(SECT) < ctl_i.given) && (4'(SECT) < rank);
		end
		acc_n  = acc_i;
		pw_n   = pw_i;
		prod_n = prod_i;
		if (SUB == 0) begin
			prod_n = FW'(pw_i * FW'(cin_i[SECT]));
		end
		if (SUB == 1) begin
			if (incl) begin
				acc_n = acc_i + prod_i;
			end
			pw_n = FW'(pw_i * FW'(dim[SECT]));
		end
		r = (SUB == 0) ? '0 : rem_i;
		q = num_i;
		for (int s = 0; s < STEPS; s++) begin
			t = {r, q[FW-1]};
			q = {q[FW-2:0], 1'b0};
			if (t >= {1'b0, dim[SECT]}) begin
				t = t - {1'b0, dim[SECT]};
				q[0] = 1'b1;
			end
			r = t[DIM_WIDTH-1:0];
		end
		num_n = q;
		rem_n = r;
		crd_n = crd_i;
		if (SUB == SUBS - 1) begin
			crd_n[SECT] = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (adv) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_o  <= ctl_i;
			acc_o  <= acc_n;
			pw_o   <= pw_n;
			prod_o <= prod_n;
			num_o  <= num_n;
			rem_o  <= rem_n;
			crd_o  <= crd_n;
			cin_o  <= cin_i;
		end
	end

endmodule

### rtl/core/tensor_index_coordinate_converter.sv
// Throughput: one item per cycle unless the output stalls; each dimension takes eight
// stages of a pipelined restoring divider that resolves four quotient bits per stage.
// A stall at the output backs up only the stages that hold items.
// Reset clears all valid bits and sets rank 0 and every dimension size to 1.
// ---------------------------------------------------------------------------
// tensor_index_coordinate_converter
// Converts tensor coordinates to a flat index and back for a configured shape.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tensor_index_coordinate_converter_defines.svh"

module tensor_index_coordinate_converter #(
	parameter int MAX_RANK  = 6,
	parameter int DIM_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ticc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [DIM_WIDTH-1:0]                  cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// flat_in, coord_count, coord_in_0 .. coord_in_N, zero fill
	input  logic [8*((35+MAX_RANK*DIM_WIDTH+7)/8)-1:0] s_tdata,
	// command
	input  logic [0:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// flat_out, coord_out_0 .. coord_out_N, bad_dimension, zero fill
	output logic [8*((33+MAX_RANK*DIM_WIDTH+7)/8)-1:0] m_tdata
);

	localparam int FW    = ticc_pkg::FLAT_W;
	localparam int IW    = ticc_pkg::CFG_IDX_W;
	localparam int SUBS  = FW / ticc_pkg::DIV_STEPS;
	localparam int NST   = MAX_RANK * SUBS;
	localparam int OUT_W = 8 * ((33 + MAX_RANK * DIM_WIDTH + 7) / 8);

	logic [2:0]           rank_q;
	logic [DIM_WIDTH-1:0] dim_q [MAX_RANK];
	logic [3:0]           rank_eff, given_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
			for (int k = 0; k < MAX_RANK; k++) begin
				dim_q[k] <= DIM_WIDTH'(1);
			end
		end else if (cfg_valid) begin
			if (cfg_index == ticc_pkg::REG_SHAPE_RANK) begin
				rank_q <= cfg_data[2:0];
			end
			for (int k = 0; k < MAX_RANK; k++) begin
				if (cfg_index == ticc_pkg::REG_DIM_BASE + IW'(k)) begin
					dim_q[k] <= cfg_data;
				end
			end
		end
	end

	assign rank_eff  = ({1'b0, rank_q} > 4'(MAX_RANK)) ? 4'(MAX_RANK) : {1'b0, rank_q};
	assign given_eff = ({1'b0, s_tdata[34:32]} > 4'(MAX_RANK)) ? 4'(MAX_RANK)
		: {1'b0, s_tdata[34:32]};

	logic                 vld_w  [NST+1];
	ticc_pkg::ctl_t       ctl_w  [NST+1];
	logic [FW-1:0]        acc_w  [NST+1];
	logic [FW-1:0]        pw_w   [NST+1];
	logic [FW-1:0]        prod_w [NST+1];
	logic [FW-1:0]        num_w  [NST+1];
	logic [DIM_WIDTH-1:0] rem_w  [NST+1];
	logic [DIM_WIDTH-1:0] crd_w  [NST+1][MAX_RANK];
	logic [DIM_WIDTH-1:0] cin_w  [NST+1][MAX_RANK];
	logic                 adv    [NST+1];

	assign vld_w[0]       = s_tvalid;
	assign ctl_w[0].cmd   = s_tuser[0];
	assign ctl_w[0].given = given_eff;
	assign acc_w[0]       = '0;
	assign pw_w[0]        = FW'(1);
	assign prod_w[0]      = '0;
	assign num_w[0]       = s_tdata[FW-1:0];
	assign rem_w[0]       = '0;

	for (genvar k = 0; k < MAX_RANK; k++) begin : g_in
		assign crd_w[0][k] = '0;
		assign cin_w[0][k] = s_tdata[35 + k*DIM_WIDTH +: DIM_WIDTH];
	end

	logic out_v_q;

	assign adv[NST]  = !out_v_q || m_tready;
	assign s_tready  = adv[0];

	for (genvar i = 0; i < NST; i++) begin : g_st
		assign adv[i] = !vld_w[i+1] || adv[i+1];
		ticc_stage #(
			.MAX_RANK (MAX_RANK),
			.DIM_WIDTH(DIM_WIDTH),
			.SECT     (i / SUBS),
			.SUB      (i % SUBS)
		) u_stage (
			.clk   (clk),
			.arst_n(arst_n),
			.adv   (adv[i]),
			.rank  (rank_eff),
			.dim   (dim_q),
			.vld_i (vld_w[i]),
			.ctl_i (ctl_w[i]),
			.acc_i (acc_w[i]),
			.pw_i  (pw_w[i]),
			.prod_i(prod_w[i]),
			.num_i (num_w[i]),
			.rem_i (rem_w[i]),
			.crd_i (crd_w[i]),
			.cin_i (cin_w[i]),
			.vld_o (vld_w[i+1]),
			.ctl_o (ctl_w[i+1]),
			.acc_o (acc_w[i+1]),
			.pw_o  (pw_w[i+1]),
			.prod_o(prod_w[i+1]),
			.num_o (num_w[i+1]),
			.rem_o (rem_w[i+1]),
			.crd_o (crd_w[i+1]),
			.cin_o (cin_w[i+1])
		);
	end

	logic [OUT_W-1:0] out_n, out_q;
	logic             bad;

	always_comb begin
		bad = 1'b0;
		for (int k = 0; k < MAX_RANK; k++) begin
			if ((dim_q[k] == '0) && (4'(k) < rank_eff)) begin
				bad = 1'b1;
			end
		end
		out_n = '0;
		if (ctl_w[NST].cmd == ticc_pkg::CMD_FOLD) begin
			out_n[FW-1:0] = acc_w[NST];
		end else if (bad) begin
			out_n[FW + MAX_RANK*DIM_WIDTH] = 1'b1;
		end else begin
			for (int k = 0; k < MAX_RANK; k++) begin
				if (4'(k) < rank_eff) begin
					out_n[FW + k*DIM_WIDTH +: DIM_WIDTH] = crd_w[NST][k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv[NST]) begin
			out_v_q <= vld_w[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NST]) begin
			out_q <= out_n;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	`TICC_ASSERT_IMPL(a_empty_ready, !out_v_q, s_tready, "input stalled with empty output")
	`TICC_ASSERT_IMPL(a_fold_clean, m_tvalid && (m_tdata[FW-1:0] != '0), !m_tdata[FW + MAX_RANK*DIM_WIDTH], "flat index and error flag both set")
	`TICC_ASSERT_IMPL(a_bad_zero, m_tvalid && m_tdata[FW + MAX_RANK*DIM_WIDTH], m_tdata[FW + MAX_RANK*DIM_WIDTH - 1:0] == '0, "error result carries data")
	`TICC_ASSERT(a_cfg_ready, cfg_ready, "configuration port not ready")

endmodule

### bench/tb_tensor_index_coordinate_converter.sv
// ---------------------------------------------------------------------------
// tb_tensor_index_coordinate_converter
// Drives coordinate folds and index splits through the converter under
// several shapes and idling phases and checks every result against a
// behavioral computation of the mixed-radix index.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tensor_index_coordinate_converter;

	localparam int RANK_MAX = 6;
	localparam int DW = 16;
	localparam int IW = ticc_pkg::CFG_IDX_W;
	localparam int SW = 8 * ((35 + RANK_MAX * DW + 7) / 8);
	localparam int MW = 8 * ((33 + RANK_MAX * DW + 7) / 8);
	localparam int SETTLE = RANK_MAX * 8 + 20;
	localparam int WATCH_LIMIT = 20000;

	typedef struct {
		logic cmd;
		logic [31:0] flat;
		logic [2:0] count;
		logic [DW-1:0] coord [RANK_MAX];
	} item_t;

	typedef struct {
		logic [31:0] flat;
		logic [DW-1:0] coord [RANK_MAX];
		logic bad;
	} res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [IW-1:0] cfg_index = '0;
	logic [DW-1:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [SW-1:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [MW-1:0] m_tdata;

	tensor_index_coordinate_converter dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	item_t pending_items [$];
	res_t expected_results [$];
	logic [2:0] shape_rank = 0;
	logic [DW-1:0] dim_size [RANK_MAX] = '{default: 1};
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_sender = 0;
	int errors = 0;
	int idle_cycles = 0;

	function automatic res_t convert(item_t it);
		res_t r;
		int rank, given, n;
		logic [31:0] acc, rest;
		r.flat = 0;
		r.bad = 0;
		foreach (r.coord[i]) r.coord[i] = 0;
		rank = shape_rank > RANK_MAX ? RANK_MAX : shape_rank;
		if (it.cmd == ticc_pkg::CMD_FOLD) begin
			given = it.count > RANK_MAX ? RANK_MAX : it.count;
			n = given < rank ? given : rank;
			if (given != 0) begin
				acc = 0;
				for (int i = 1; i < n; i++) begin
					acc = acc + it.coord[n - i];
					acc = acc * dim_size[n - i - 1];
				end
				r.flat = acc + it.coord[0];
			end
		end else begin
			rest = it.flat;
			for (int i = 0; i < rank; i++) begin
				if (dim_size[i] == 0) begin
					r.bad = 1;
					break;
				end
				r.coord[i] = DW'(rest % dim_size[i]);
				rest = rest / dim_size[i];
			end
			if (r.bad) foreach (r.coord[i]) r.coord[i] = 0;
		end
		return r;
	endfunction

	function automatic logic [SW-1:0] pack_item(item_t it);
		logic [SW-1:0] d;
		d = '0;
		d[31:0] = it.flat;
		d[34:32] = it.count;
		for (int i = 0; i < RANK_MAX; i++) d[35 + i * DW +: DW] = it.coord[i];
		return d;
	endfunction

	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_results.insert(expected_results.size(),
				convert(pending_items.pop_front()));
		end
		if (!s_tvalid || s_tready) begin
			if (!hold_sender && pending_items.size() != 0
					&& $urandom_range(99) >= send_idle) begin
				s_tvalid <= 1;
				s_tdata <= pack_item(pending_items[0]);
				s_tuser <= pending_items[0].cmd;
			end else begin
				s_tvalid <= 0;
			end
		end
		m_tready <= $urandom_range(99) >= recv_stall;
	end

	always @(posedge clk) begin
		res_t e;
		logic [31:0] fo;
		logic bd;
		logic [DW-1:0] co;
		if (m_tvalid && m_tready) begin
			fo = m_tdata[31:0];
			bd = m_tdata[32 + RANK_MAX * DW];
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, actual %h", $time, m_tdata);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (fo !== e.flat) begin
					$display("%0t: flat_out expected %h actual %h", $time, e.flat, fo);
					errors++;
				end
				if (bd !== e.bad) begin
					$display("%0t: bad_dimension expected %b actual %b", $time, e.bad, bd);
					errors++;
				end
				for (int i = 0; i < RANK_MAX; i++) begin
					co = m_tdata[32 + i * DW +: DW];
					if (co !== e.coord[i]) begin
						$display("%0t: coord_out_%0d expected %h actual %h",
							$time, i, e.coord[i], co);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
				|| (pending_items.size() == 0 && expected_results.size() == 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		if (idx == ticc_pkg::REG_SHAPE_RANK) shape_rank = val[2:0];
		else if (idx >= ticc_pkg::REG_DIM_BASE && idx < ticc_pkg::REG_DIM_BASE + RANK_MAX)
			dim_size[idx - ticc_pkg::REG_DIM_BASE] = val;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic add_item(input logic cmd, input logic [31:0] flat,
			input logic [2:0] count, input logic [DW-1:0] c);
		item_t it;
		it.cmd = cmd;
		it.flat = flat;
		it.count = count;
		foreach (it.coord[i]) it.coord[i] = c;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic add_random(input int n, input bit small_vals);
		item_t it;
		for (int k = 0; k < n; k++) begin
			it.cmd = 1'($urandom_range(1));
			it.count = 3'($urandom_range(7));
			it.flat = $urandom_range(3) == 0 ? $urandom_range(4095) : $urandom;
			foreach (it.coord[i])
				it.coord[i] = small_vals ? DW'($urandom_range(dim_size[i]))
					: DW'($urandom);
			pending_items.insert(pending_items.size(), it);
		end
	endtask

	task automatic random_shape(input bit allow_zero);
		write_reg(ticc_pkg::REG_SHAPE_RANK, DW'($urandom_range(7)));
		for (int i = 0; i < RANK_MAX; i++)
			write_reg(IW'(ticc_pkg::REG_DIM_BASE + i),
				(allow_zero && $urandom_range(7) == 0) ? DW'(0)
				: ($urandom_range(3) == 0 ? DW'($urandom) : DW'($urandom_range(1, 40))));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Reset shape: rank zero.
		add_item(ticc_pkg::CMD_FOLD, 0, 0, 16'h1234);
		add_item(ticc_pkg::CMD_FOLD, 0, 3, 16'hFFFF);
		add_item(ticc_pkg::CMD_SPLIT, 32'hFFFF_FFFF, 0, 0);
		drain();

		write_reg(ticc_pkg::REG_SHAPE_RANK, 7);
		for (int i = 0; i < RANK_MAX; i++)
			write_reg(IW'(ticc_pkg::REG_DIM_BASE + i), 16'hFFFF);
		write_reg(IW'(ticc_pkg::REG_DIM_BASE + RANK_MAX), 16'h0005);
		add_item(ticc_pkg::CMD_FOLD, 0, 7, 16'hFFFF);
		add_item(ticc_pkg::CMD_FOLD, 0, 6, 16'h0000);
		add_item(ticc_pkg::CMD_FOLD, 0, 1, 16'hABCD);
		add_item(ticc_pkg::CMD_FOLD, 32'hFFFF_FFFF, 0, 16'hFFFF);
		add_item(ticc_pkg::CMD_SPLIT, 32'hFFFF_FFFF, 7, 16'hFFFF);
		add_item(ticc_pkg::CMD_SPLIT, 0, 0, 0);
		add_item(ticc_pkg::CMD_SPLIT, 32'h8000_0001, 0, 0);
		drain();

		write_reg(ticc_pkg::REG_SHAPE_RANK, 3);
		write_reg(IW'(ticc_pkg::REG_DIM_BASE + 1), 0);
		add_item(ticc_pkg::CMD_FOLD, 0, 3, 16'h0007);
		add_item(ticc_pkg::CMD_SPLIT, 32'h0001_2345, 0, 0);
		drain();
		write_reg(ticc_pkg::REG_SHAPE_RANK, 1);
		write_reg(ticc_pkg::REG_DIM_BASE, 1);
		add_item(ticc_pkg::CMD_SPLIT, 32'hDEAD_BEEF, 0, 0);
		add_item(ticc_pkg::CMD_FOLD, 0, 5, 16'h5555);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 84; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 84; end
				default: begin send_idle = 15; recv_stall = 15; end
			endcase
			random_shape(phase % 2 == 1);
			add_random(30, phase % 3 == 0);
			if (phase == 4) begin
				repeat (20) @(posedge clk);
				hold_sender = 1;
				while (s_tvalid || expected_results.size() != 0) @(posedge clk);
				hold_sender = 0;
			end
			add_random(30, 0);
			drain();
		end

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
